// File: rtl/tnu_pkg.sv
// Shared types and constants for the torus normal unit.
`default_nettype none
package tnu_pkg;

	localparam int COORD_W = 24;
	localparam int RAD_W   = 23;
	localparam int NORM_W  = 16;
	localparam int UNIT_ONE = 16384;

	localparam int SQ1_W = 48;
	localparam int SQ1_K = SQ1_W / 2;
	localparam int DV1_NW = 48;
	localparam int DV1_DW = 25;
	localparam int DV1_QW = 24;

	localparam int DX_W  = 26;
	localparam int M_W   = 50;
	localparam int SQ2_W = 62;
	localparam int SQ2_K = SQ2_W / 2;
	localparam int DV2_NW = 46;
	localparam int DV2_DW = 32;
	localparam int DV2_QW = 16;

	localparam int LAT = 3 + SQ1_K + 2 + DV1_QW + 3 + SQ2_K + 1 + DV2_QW + 1;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic                      last_point;
	} in_t;

	typedef struct packed {
		logic signed [NORM_W-1:0] normal_x;
		logic signed [NORM_W-1:0] normal_y;
		logic signed [NORM_W-1:0] normal_z;
		logic                     degenerate;
		logic                     last_result;
	} out_t;

endpackage
`default_nettype wire

// File: rtl/torus_normal_unit_core.sv
// Top level of the torus normal unit: square, root, scale, divide, normalize.
// Throughput: one beat per cycle; busy is always low, every stage is a register.
// Pipeline depth is set mainly by the chains of root and divider cells, one digit per cell.
// Reset clears the valid line and ring_radius; data registers are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module torus_normal_unit_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output      logic                            busy,
	input  wire tnu_pkg::in_t                    item,
	output      logic                            done,
	output      tnu_pkg::out_t                   result,
	input  wire logic                            cfg_we,
	input  wire logic [tnu_pkg::RAD_W-1:0]       cfg_data
);
	localparam int CW   = tnu_pkg::COORD_W;
	localparam int S1W  = tnu_pkg::SQ1_W;
	localparam int S1K  = tnu_pkg::SQ1_K;
	localparam int D1N  = tnu_pkg::DV1_NW;
	localparam int D1D  = tnu_pkg::DV1_DW;
	localparam int D1Q  = tnu_pkg::DV1_QW;
	localparam int DXW  = tnu_pkg::DX_W;
	localparam int MW   = tnu_pkg::M_W;
	localparam int S2W  = tnu_pkg::SQ2_W;
	localparam int S2K  = tnu_pkg::SQ2_K;
	localparam int D2N  = tnu_pkg::DV2_NW;
	localparam int D2D  = tnu_pkg::DV2_DW;
	localparam int D2Q  = tnu_pkg::DV2_QW;
	localparam int LAT  = tnu_pkg::LAT;
	localparam int SB1W = 3 * CW + 2;
	localparam int SB3W = 3 * DXW + 2;

	logic [tnu_pkg::RAD_W-1:0] ring_radius_q;
	logic [LAT-1:0]            valid_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_radius_q <= '0;
			valid_q       <= '0;
		end else begin
			if (cfg_we) begin
				ring_radius_q <= cfg_data;
			end
			valid_q <= {valid_q[LAT-2:0], start & ~busy};
		end
	end

	// stage 1: capture
	tnu_pkg::in_t in_s1;
	always_ff @(posedge clk) begin
		in_s1 <= item;
	end

	// stage 2: squares
	logic [S1W-1:0] sqx_s2, sqz_s2;
	tnu_pkg::in_t   in_s2;
	always_ff @(posedge clk) begin
		sqx_s2 <= S1W'(in_s1.point_x * in_s1.point_x);
		sqz_s2 <= S1W'(in_s1.point_z * in_s1.point_z);
		in_s2  <= in_s1;
	end

	// stage 3: sum
	logic [S1W-1:0] s_s3;
	tnu_pkg::in_t   in_s3;
	always_ff @(posedge clk) begin
		s_s3  <= sqx_s2 + sqz_s2;
		in_s3 <= in_s2;
	end

	// root chain one
	logic [S1W-1:0] r1_rad  [S1K+1];
	logic [S1K+1:0] r1_rem  [S1K+1];
	logic [S1K-1:0] r1_root [S1K+1];
	assign r1_rad[0]  = s_s3;
	assign r1_rem[0]  = '0;
	assign r1_root[0] = '0;
	for (genvar g = 0; g < S1K; g++) begin : g_sq1
		tnu_sqrt_cell #(.W(S1W)) u_cell (
			.clk    (clk),
			.rad_i  (r1_rad[g]),
			.rem_i  (r1_rem[g]),
			.root_i (r1_root[g]),
			.rad_o  (r1_rad[g+1]),
			.rem_o  (r1_rem[g+1]),
			.root_o (r1_root[g+1])
		);
	end

	logic [SB1W-1:0] sb1_q [S1K];
	always_ff @(posedge clk) begin
		sb1_q[0] <= {in_s3.point_x, in_s3.point_y, in_s3.point_z, in_s3.last_point,
			s_s3 == '0};
		for (int i = 1; i < S1K; i++) begin
			sb1_q[i] <= sb1_q[i-1];
		end
	end

	logic signed [CW-1:0] x_r1, y_r1, z_r1;
	logic                 last_r1, s0_r1;
	assign {x_r1, y_r1, z_r1, last_r1, s0_r1} = sb1_q[S1K-1];

	// stage 4: scale by ring radius
	logic [CW-1:0]         magx, magz;
	logic [D1N-2:0]        prx_s4, prz_s4;
	logic [S1K-1:0]        r_s4;
	logic [SB1W-1:0]       sb_s4;
	assign magx = x_r1[CW-1] ? (~x_r1 + 1'b1) : x_r1;
	assign magz = z_r1[CW-1] ? (~z_r1 + 1'b1) : z_r1;
	always_ff @(posedge clk) begin
		prx_s4 <= (D1N-1)'(magx * ring_radius_q);
		prz_s4 <= (D1N-1)'(magz * ring_radius_q);
		r_s4   <= r1_root[S1K];
		sb_s4  <= sb1_q[S1K-1];
	end

	// stage 5: rounding numerators
	logic [D1N-1:0]  nx_s5, nz_s5;
	logic [D1D-1:0]  dv1_s5;
	logic [SB1W-1:0] sb_s5;
	always_ff @(posedge clk) begin
		nx_s5  <= {prx_s4, 1'b0} + D1N'(r_s4);
		nz_s5  <= {prz_s4, 1'b0} + D1N'(r_s4);
		dv1_s5 <= {r_s4, 1'b0};
		sb_s5  <= sb_s4;
	end

	// divider chains one
	logic [D1N-1:0] dx_num [D1Q+1];
	logic [D1D-1:0] dx_den [D1Q+1];
	logic [D1Q-1:0] dx_quo [D1Q+1];
	logic [D1N-1:0] dz_num [D1Q+1];
	logic [D1D-1:0] dz_den [D1Q+1];
	logic [D1Q-1:0] dz_quo [D1Q+1];
	assign dx_num[0] = nx_s5;
	assign dx_den[0] = dv1_s5;
	assign dx_quo[0] = '0;
	assign dz_num[0] = nz_s5;
	assign dz_den[0] = dv1_s5;
	assign dz_quo[0] = '0;
	for (genvar g = 0; g < D1Q; g++) begin : g_dv1
		tnu_div_cell #(.NW(D1N), .DW(D1D), .QW(D1Q), .BIT(D1Q-1-g)) u_cx (
			.clk   (clk),
			.num_i (dx_num[g]),
			.den_i (dx_den[g]),
			.quo_i (dx_quo[g]),
			.num_o (dx_num[g+1]),
			.den_o (dx_den[g+1]),
			.quo_o (dx_quo[g+1])
		);
		tnu_div_cell #(.NW(D1N), .DW(D1D), .QW(D1Q), .BIT(D1Q-1-g)) u_cz (
			.clk   (clk),
			.num_i (dz_num[g]),
			.den_i (dz_den[g]),
			.quo_i (dz_quo[g]),
			.num_o (dz_num[g+1]),
			.den_o (dz_den[g+1]),
			.quo_o (dz_quo[g+1])
		);
	end

	logic [SB1W-1:0] sb2_q [D1Q];
	always_ff @(posedge clk) begin
		sb2_q[0] <= sb_s5;
		for (int i = 1; i < D1Q; i++) begin
			sb2_q[i] <= sb2_q[i-1];
		end
	end

	logic signed [CW-1:0] x_d1, y_d1, z_d1;
	logic                 last_d1, s0_d1;
	assign {x_d1, y_d1, z_d1, last_d1, s0_d1} = sb2_q[D1Q-1];

	// stage 6: offset from ring centre
	logic [DXW-1:0] qx_e, qz_e, cx, cz;
	logic [DXW-1:0] dx_s6, dy_s6, dz_s6;
	logic           last_s6, s0_s6;
	assign qx_e = DXW'(dx_quo[D1Q]);
	assign qz_e = DXW'(dz_quo[D1Q]);
	assign cx   = x_d1[CW-1] ? (~qx_e + 1'b1) : qx_e;
	assign cz   = z_d1[CW-1] ? (~qz_e + 1'b1) : qz_e;
	always_ff @(posedge clk) begin
		dx_s6   <= {{(DXW-CW){x_d1[CW-1]}}, x_d1} - cx;
		dz_s6   <= {{(DXW-CW){z_d1[CW-1]}}, z_d1} - cz;
		dy_s6   <= {{(DXW-CW){y_d1[CW-1]}}, y_d1};
		last_s6 <= last_d1;
		s0_s6   <= s0_d1;
	end

	// stage 7: squares of the offset
	logic [MW-1:0]  ex_s7, ey_s7, ez_s7;
	logic [DXW-1:0] dx_s7, dy_s7, dz_s7;
	logic           last_s7, s0_s7;
	always_ff @(posedge clk) begin
		ex_s7   <= MW'($signed(dx_s6) * $signed(dx_s6));
		ey_s7   <= MW'($signed(dy_s6) * $signed(dy_s6));
		ez_s7   <= MW'($signed(dz_s6) * $signed(dz_s6));
		dx_s7   <= dx_s6;
		dy_s7   <= dy_s6;
		dz_s7   <= dz_s6;
		last_s7 <= last_s6;
		s0_s7   <= s0_s6;
	end

	// stage 8: squared length
	logic [MW-1:0]  m_s8;
	logic [DXW-1:0] dx_s8, dy_s8, dz_s8;
	logic           last_s8, s0_s8;
	always_ff @(posedge clk) begin
		m_s8    <= ex_s7 + ey_s7 + ez_s7;
		dx_s8   <= dx_s7;
		dy_s8   <= dy_s7;
		dz_s8   <= dz_s7;
		last_s8 <= last_s7;
		s0_s8   <= s0_s7;
	end

	// root chain two
	logic [S2W-1:0] r2_rad  [S2K+1];
	logic [S2K+1:0] r2_rem  [S2K+1];
	logic [S2K-1:0] r2_root [S2K+1];
	assign r2_rad[0]  = {m_s8, {(S2W-MW){1'b0}}};
	assign r2_rem[0]  = '0;
	assign r2_root[0] = '0;
	for (genvar g = 0; g < S2K; g++) begin : g_sq2
		tnu_sqrt_cell #(.W(S2W)) u_cell (
			.clk    (clk),
			.rad_i  (r2_rad[g]),
			.rem_i  (r2_rem[g]),
			.root_i (r2_root[g]),
			.rad_o  (r2_rad[g+1]),
			.rem_o  (r2_rem[g+1]),
			.root_o (r2_root[g+1])
		);
	end

	logic [SB3W-1:0] sb3_q [S2K];
	always_ff @(posedge clk) begin
		sb3_q[0] <= {dx_s8, dy_s8, dz_s8, last_s8, s0_s8 | (m_s8 == '0)};
		for (int i = 1; i < S2K; i++) begin
			sb3_q[i] <= sb3_q[i-1];
		end
	end

	logic [DXW-1:0] dx_r2, dy_r2, dz_r2;
	logic           last_r2, dg_r2;
	assign {dx_r2, dy_r2, dz_r2, last_r2, dg_r2} = sb3_q[S2K-1];

	// stage 9: normalizing numerators
	logic [DXW-2:0] ax, ay, az;
	logic [D2N-1:0] kx_s9, ky_s9, kz_s9;
	logic [D2D-1:0] dv2_s9;
	logic [4:0]     sb_s9;
	assign ax = dx_r2[DXW-1] ? (DXW-1)'(~dx_r2 + 1'b1) : dx_r2[DXW-2:0];
	assign ay = dy_r2[DXW-1] ? (DXW-1)'(~dy_r2 + 1'b1) : dy_r2[DXW-2:0];
	assign az = dz_r2[DXW-1] ? (DXW-1)'(~dz_r2 + 1'b1) : dz_r2[DXW-2:0];
	always_ff @(posedge clk) begin
		kx_s9  <= {ax, {(D2N-DXW+1){1'b0}}} + D2N'(r2_root[S2K]);
		ky_s9  <= {ay, {(D2N-DXW+1){1'b0}}} + D2N'(r2_root[S2K]);
		kz_s9  <= {az, {(D2N-DXW+1){1'b0}}} + D2N'(r2_root[S2K]);
		dv2_s9 <= {r2_root[S2K], 1'b0};
		sb_s9  <= {dx_r2[DXW-1], dy_r2[DXW-1], dz_r2[DXW-1], last_r2, dg_r2};
	end

	// divider chains two
	logic [D2N-1:0] n_num [3][D2Q+1];
	logic [D2D-1:0] n_den [3][D2Q+1];
	logic [D2Q-1:0] n_quo [3][D2Q+1];
	assign n_num[0][0] = kx_s9;
	assign n_num[1][0] = ky_s9;
	assign n_num[2][0] = kz_s9;
	for (genvar c = 0; c < 3; c++) begin : g_lane
		assign n_den[c][0] = dv2_s9;
		assign n_quo[c][0] = '0;
		for (genvar g = 0; g < D2Q; g++) begin : g_dv2
			tnu_div_cell #(.NW(D2N), .DW(D2D), .QW(D2Q), .BIT(D2Q-1-g)) u_cell (
				.clk   (clk),
				.num_i (n_num[c][g]),
				.den_i (n_den[c][g]),
				.quo_i (n_quo[c][g]),
				.num_o (n_num[c][g+1]),
				.den_o (n_den[c][g+1]),
				.quo_o (n_quo[c][g+1])
			);
		end
	end

	logic [4:0] sb4_q [D2Q];
	always_ff @(posedge clk) begin
		sb4_q[0] <= sb_s9;
		for (int i = 1; i < D2Q; i++) begin
			sb4_q[i] <= sb4_q[i-1];
		end
	end

	// stage 10: saturate, sign, drop on degenerate
	logic [D2Q-1:0] sat [3];
	logic [D2Q-1:0] sgn [3];
	logic [2:0]     neg;
	logic           last_n, dg_n;
	assign {neg, last_n, dg_n} = sb4_q[D2Q-1];
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sat[c] = (n_quo[c][D2Q] > D2Q'(tnu_pkg::UNIT_ONE)) ?
				D2Q'(tnu_pkg::UNIT_ONE) : n_quo[c][D2Q];
			sgn[c] = dg_n ? '0 : (neg[2-c] ? (~sat[c] + 1'b1) : sat[c]);
		end
	end

	tnu_pkg::out_t res_s10;
	always_ff @(posedge clk) begin
		res_s10.normal_x    <= sgn[0];
		res_s10.normal_y    <= sgn[1];
		res_s10.normal_z    <= sgn[2];
		res_s10.degenerate  <= dg_n;
		res_s10.last_result <= last_n;
	end

	assign result = res_s10;
	assign done   = valid_q[LAT-1];

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(LAT) done)
		else $error("beat lost in pipeline");
	a_deg: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.degenerate |->
		result.normal_x == 0 && result.normal_y == 0 && result.normal_z == 0)
		else $error("degenerate beat carries a normal");
	a_nz: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.degenerate |->
		result.normal_x != 0 || result.normal_y != 0 || result.normal_z != 0)
		else $error("zero normal without degenerate flag");
	a_rng: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.normal_x <= 16'sd16384 && result.normal_x >= -16'sd16384 &&
		result.normal_z <= 16'sd16384 && result.normal_z >= -16'sd16384)
		else $error("normal out of range");
endmodule
`default_nettype wire

// File: rtl/tnu_sqrt_cell.sv
// One digit step of a pipelined integer square root.
`default_nettype none
module tnu_sqrt_cell #(
	parameter int W = 48
) (
	input  wire logic             clk,
	input  wire logic [W-1:0]     rad_i,
	input  wire logic [W/2+1:0]   rem_i,
	input  wire logic [W/2-1:0]   root_i,
	output      logic [W-1:0]     rad_o,
	output      logic [W/2+1:0]   rem_o,
	output      logic [W/2-1:0]   root_o
);
	localparam int K = W / 2;

	logic [K+3:0] cur;
	logic [K+3:0] trial;
	logic [K+3:0] diff;
	logic         take;

	always_comb begin
		cur   = {rem_i, rad_i[W-1:W-2]};
		trial = {2'b00, root_i, 2'b01};
		diff  = cur - trial;
		take  = (cur >= trial);
	end

	always_ff @(posedge clk) begin
		rad_o <= {rad_i[W-3:0], 2'b00};
		if (take) begin
			rem_o  <= diff[K+1:0];
			root_o <= {root_i[K-2:0], 1'b1};
		end else begin
			rem_o  <= cur[K+1:0];
			root_o <= {root_i[K-2:0], 1'b0};
		end
	end
endmodule
`default_nettype wire

// File: rtl/tnu_div_cell.sv
// One quotient bit of a pipelined restoring divider.
`default_nettype none
module tnu_div_cell #(
	parameter int NW  = 48,
	parameter int DW  = 25,
	parameter int QW  = 24,
	parameter int BIT = 0
) (
	input  wire logic          clk,
	input  wire logic [NW-1:0] num_i,
	input  wire logic [DW-1:0] den_i,
	input  wire logic [QW-1:0] quo_i,
	output      logic [NW-1:0] num_o,
	output      logic [DW-1:0] den_o,
	output      logic [QW-1:0] quo_o
);
	localparam int CW = (NW > DW + QW) ? NW : DW + QW;

	logic [CW-1:0] res;
	logic [CW-1:0] dsh;
	logic [CW-1:0] diff;

	always_comb begin
		res  = CW'(num_i);
		dsh  = CW'(den_i) << BIT;
		diff = res - dsh;
	end

	always_ff @(posedge clk) begin
		den_o <= den_i;
		if (res >= dsh) begin
			num_o <= diff[NW-1:0];
			quo_o <= quo_i | (QW'(1) << BIT);
		end else begin
			num_o <= num_i;
			quo_o <= quo_i;
		end
	end
endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the torus normal unit: predicted normals against the pipeline.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

	localparam int NUM_RANDOM = 1330;
	localparam longint CYCLE_LIMIT = 400000;

	class normal_board;
		tnu_pkg::out_t pending[$];
		int   mismatches;
		int   beats_checked;

		function new();
			mismatches = 0;
			beats_checked = 0;
		endfunction

		function longint unsigned root(longint unsigned v);
			longint unsigned res;
			longint unsigned bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > v) bitv = bitv >> 2;
			while (bitv != 0) begin
				if (v >= res + bitv) begin
					v = v - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
				bitv = bitv >> 2;
			end
			return res;
		endfunction

		function longint round_div(longint num, longint unsigned den);
			longint unsigned mag;
			longint unsigned q;
			mag = (num < 0) ? longint'(-num) : num;
			q = (2 * mag + den) / (2 * den);
			return (num < 0) ? -longint'(q) : longint'(q);
		endfunction

		function longint clamp_unit(longint v);
			if (v > tnu_pkg::UNIT_ONE) return tnu_pkg::UNIT_ONE;
			if (v < -tnu_pkg::UNIT_ONE) return -tnu_pkg::UNIT_ONE;
			return v;
		endfunction

		function void note_point(tnu_pkg::in_t p, logic [tnu_pkg::RAD_W-1:0] radius);
			tnu_pkg::out_t e;
			longint x, y, z, dx, dz, rad, len;
			longint unsigned s, r, m;
			x = p.point_x;
			y = p.point_y;
			z = p.point_z;
			rad = radius;
			e = '0;
			e.degenerate = 1'b1;
			e.last_result = p.last_point;
			s = x * x + z * z;
			if (s != 0) begin
				r = root(s);
				dx = x - round_div(x * rad, r);
				dz = z - round_div(z * rad, r);
				m = dx * dx + y * y + dz * dz;
				if (m != 0) begin
					len = root(m << 12);
					e.normal_x = clamp_unit(round_div(dx * (64'sd1 << 20), len));
					e.normal_y = clamp_unit(round_div(y * (64'sd1 << 20), len));
					e.normal_z = clamp_unit(round_div(dz * (64'sd1 << 20), len));
					e.degenerate = 1'b0;
				end
			end
			pending.push_back(e);
		endfunction

		function void check_normal(tnu_pkg::out_t got);
			tnu_pkg::out_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %p", got);
				return;
			end
			e = pending.pop_front();
			beats_checked++;
			if (got.normal_x !== e.normal_x || got.normal_y !== e.normal_y ||
			    got.normal_z !== e.normal_z || got.degenerate !== e.degenerate ||
			    got.last_result !== e.last_result) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %p got %p", e, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	tnu_pkg::in_t  item;
	logic done;
	tnu_pkg::out_t result;
	logic cfg_we;
	logic [tnu_pkg::RAD_W-1:0] cfg_data;
	logic [tnu_pkg::RAD_W-1:0] radius;
	logic quiet;
	longint cycles;
	int directed_cnt;
	int degen_cnt;
	normal_board board;

	torus_normal_unit_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && start && !busy) board.note_point(item, radius);
		if (arst_n && done) begin
			if (result.degenerate) degen_cnt <= degen_cnt + 1;
			board.check_normal(result);
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_top: FAIL");
			$finish;
		end
	end

	task automatic send_point(tnu_pkg::in_t p);
		item <= p;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			item <= tnu_pkg::in_t'({$urandom(), $urandom(), $urandom()});
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
	endtask

	task automatic drain_and_set(logic [tnu_pkg::RAD_W-1:0] val);
		start <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (tnu_pkg::LAT + 5) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= val;
		radius <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [tnu_pkg::COORD_W-1:0] rand_coord(int mode);
		case (mode)
			0: return tnu_pkg::COORD_W'($urandom());
			1: return tnu_pkg::COORD_W'($signed(tnu_pkg::COORD_W'($urandom_range(0, 32))) - 16);
			2: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
			default: return tnu_pkg::COORD_W'($signed(tnu_pkg::COORD_W'(
				$urandom_range(0, 1 << 17))) - (1 << 16));
		endcase
	endfunction

	function automatic tnu_pkg::in_t make_point(logic signed [tnu_pkg::COORD_W-1:0] x,
	                                            logic signed [tnu_pkg::COORD_W-1:0] y,
	                                            logic signed [tnu_pkg::COORD_W-1:0] z,
	                                            logic last);
		tnu_pkg::in_t p;
		p.point_x = x;
		p.point_y = y;
		p.point_z = z;
		p.last_point = last;
		return p;
	endfunction

	initial begin
		logic signed [tnu_pkg::COORD_W-1:0] ex[6];
		logic [tnu_pkg::RAD_W-1:0] settings[5];
		tnu_pkg::in_t p;
		int phase;
		board = new();
		cycles = 0;
		degen_cnt = 0;
		directed_cnt = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		radius = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, axis points, ring-circle points
		ex = '{24'sh7FFFFF, 24'sh800000, 24'sh0, 24'sh1, -24'sh1, 24'sh001000};
		drain_and_set(23'h001000);
		for (int i = 0; i < 6; i++) begin
			send_point(make_point(ex[i], ex[(i + 2) % 6], ex[(i + 4) % 6], i[0]));
			directed_cnt++;
		end
		send_point(make_point(0, 24'sh123456, 0, 1'b0));
		send_point(make_point(0, 0, 0, 1'b1));
		send_point(make_point(24'sh001000, 0, 0, 1'b0));
		send_point(make_point(0, 0, -24'sh001000, 1'b1));
		send_point(make_point(24'sh000003, 0, 24'sh000004, 1'b0));
		directed_cnt += 5;
		drain_and_set(23'h7FFFFF);
		send_point(make_point(24'sh800000, 24'sh800000, 24'sh800000, 1'b1));
		send_point(make_point(24'sh7FFFFF, 0, 24'sh7FFFFF, 1'b0));
		send_point(make_point(24'sh000001, 24'sh7FFFFF, 0, 1'b1));
		drain_and_set(23'h0);
		send_point(make_point(24'sh000005, 0, 0, 1'b0));
		send_point(make_point(24'sh800000, 24'sh7FFFFF, 24'sh000001, 1'b1));
		directed_cnt += 5;

		settings = '{23'h0, 23'h7FFFFF, 23'h004000, 23'($urandom()), 23'h000010};
		for (phase = 0; phase < 5; phase++) begin
			drain_and_set(phase == 3 ? 23'($urandom()) : settings[phase]);
			if (phase == 4) quiet = 1'b1;
			for (int n = 0; n < NUM_RANDOM / 5; n++) begin
				p = make_point(rand_coord($urandom_range(0, 3)),
					rand_coord($urandom_range(0, 3)),
					rand_coord($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
				// land some points exactly on the ring circle
				if ($urandom_range(0, 9) == 0 && radius != 0) begin
					p.point_x = {1'b0, radius};
					p.point_y = 0;
					p.point_z = 0;
				end
				if ($urandom_range(0, 19) == 0) begin
					p.point_x = 0;
					p.point_z = 0;
				end
				send_point(p);
			end
		end
		start <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (tnu_pkg::LAT + 10) @(negedge clk);

		$display("checked %0d normals (%0d degenerate) across eight ring radius values",
			board.beats_checked, degen_cnt);
		$display("directed points: %0d, mismatches: %0d", directed_cnt, board.mismatches);
		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire

// File: filelist.f
rtl/tnu_pkg.sv
rtl/tnu_sqrt_cell.sv
rtl/tnu_div_cell.sv
rtl/torus_normal_unit_core.sv
tb/sv/tb_top.sv
